// ===== rtl/gnw_pkg.sv =====
package gnw_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_SET    = 3'd1,
        OP_QUERY  = 3'd2,
        OP_INDEX  = 3'd3,
        OP_SEARCH = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  cell_x;
        logic [7:0]  cell_z;
        logic        walk_value;
        logic [11:0] linear_index;
        logic [4:0]  search_radius;
    } in_item_t;

    typedef struct packed {
        logic       hit;
        logic [8:0] out_x;
        logic [8:0] out_z;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } exec_state_t;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

endpackage

// ===== rtl/gnw_front.sv =====
// Input stage: saturate the radius and park items in a two-entry queue.
module gnw_front #(
    parameter int MAX_SEARCH_RADIUS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gnw_pkg::in_item_t s_item,
    output logic              q_valid,
    input  logic              q_ready,
    output gnw_pkg::in_item_t q_item
);
    gnw_pkg::in_item_t mem_reg [2];
    logic              wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    gnw_pkg::in_item_t fixed;

    // Clamp the search radius on the way in
    always_comb begin
        fixed = s_item;
        if (32'(s_item.search_radius) > MAX_SEARCH_RADIUS) begin
            fixed.search_radius = 5'(MAX_SEARCH_RADIUS);
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rptr_reg];

    // Advance pointers
    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (s_valid && s_ready) begin
            wptr_next = ~wptr_reg;
            cnt_next  = cnt_next + 2'd1;
        end
        if (q_valid && q_ready) begin
            rptr_next = ~rptr_reg;
            cnt_next  = cnt_next - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mem_reg[wptr_reg] <= fixed;
        end
    end
endmodule

// ===== rtl/gnw_exec.sv =====
// Back end: owns the map memory, runs clears, sets, queries and ring scans.
module gnw_exec #(
    parameter int MAX_GRID_DIM = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [6:0]         grid_width,
    input  logic [6:0]         grid_height,
    input  logic               q_valid,
    output logic               q_ready,
    input  gnw_pkg::in_item_t  q_item,
    output logic               m_valid,
    input  logic               m_ready,
    output gnw_pkg::out_item_t m_item
);
    localparam int CELLS = MAX_GRID_DIM * MAX_GRID_DIM;
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = $clog2(MAX_GRID_DIM + 1);

    logic                   map_mem [CELLS];
    logic                   rd_reg;
    logic [AW-1:0]          clr_reg, clr_next;
    gnw_pkg::exec_state_t   st_reg, st_next;
    gnw_pkg::in_item_t      it_reg;
    logic signed [9:0]      dx_reg, dx_next, dz_reg, dz_next;
    logic [4:0]             r_reg, r_next;
    logic                   ohit_reg;
    logic [8:0]             ox_reg, oz_reg;
    logic                   ov_reg;
    logic                   boot_reg;
    logic [DW-1:0]          w_eff, h_eff;
    logic signed [10:0]     tx, tz;
    logic                   in_grid;
    logic [AW-1:0]          addr, idx_addr;
    logic [2*DW:0]          total;
    logic                   idx_ok;
    logic                   take, fin;
    logic                   row_edge;
    logic                   chk_inside_reg;
    logic signed [9:0]      rr;

    // Saturate the grid size to 1..MAX_GRID_DIM
    always_comb begin
        w_eff = (grid_width == 7'd0) ? DW'(1) :
                (32'(grid_width) > MAX_GRID_DIM) ? DW'(MAX_GRID_DIM) : DW'(grid_width);
        h_eff = (grid_height == 7'd0) ? DW'(1) :
                (32'(grid_height) > MAX_GRID_DIM) ? DW'(MAX_GRID_DIM) : DW'(grid_height);
    end

    // Current probe cell
    assign rr = 10'(signed'({1'b0, r_reg}));
    assign tx = 11'(signed'(it_reg.cell_x)) + 11'(dx_reg);
    assign tz = 11'(signed'(it_reg.cell_z)) + 11'(dz_reg);
    assign in_grid = !tx[10] && !tz[10] && (tx < 11'(signed'({1'b0, w_eff})))
                     && (tz < 11'(signed'({1'b0, h_eff})));
    assign addr = AW'(32'(tz[9:0]) * 32'(w_eff) + 32'(tx[9:0]));
    assign total = (2*DW+1)'(w_eff) * (2*DW+1)'(h_eff);
    assign idx_ok = (32'(it_reg.linear_index) < 32'(total));
    assign idx_addr = AW'(it_reg.linear_index);
    assign row_edge = (dz_reg == -rr) || (dz_reg == rr);

    assign take    = q_valid && q_ready;
    assign q_ready = (st_reg == gnw_pkg::ST_IDLE) && !ov_reg;
    assign m_valid = ov_reg;
    assign m_item  = '{hit: ohit_reg, out_x: ox_reg, out_z: oz_reg};
    assign fin     = (st_reg == gnw_pkg::ST_DONE);

    // Next state; the sweep after reset returns to idle without a result
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            gnw_pkg::ST_IDLE:  if (take) begin
                st_next = (q_item.op == gnw_pkg::OP_CLEAR) ? gnw_pkg::ST_CLEAR : gnw_pkg::ST_READ;
            end
            gnw_pkg::ST_CLEAR: if (clr_reg == AW'(CELLS - 1)) begin
                st_next = boot_reg ? gnw_pkg::ST_IDLE : gnw_pkg::ST_DONE;
            end
            gnw_pkg::ST_READ:  st_next = gnw_pkg::ST_CHECK;
            gnw_pkg::ST_CHECK: begin
                if (it_reg.op != gnw_pkg::OP_SEARCH) st_next = gnw_pkg::ST_DONE;
                else if (chk_inside_reg && rd_reg) st_next = gnw_pkg::ST_DONE;
                else if (dz_reg == rr && dx_reg == rr) begin
                    st_next = (r_reg == it_reg.search_radius) ? gnw_pkg::ST_DONE
                                                                : gnw_pkg::ST_READ;
                end else st_next = gnw_pkg::ST_READ;
            end
            gnw_pkg::ST_DONE:  st_next = gnw_pkg::ST_IDLE;
            default:           st_next = gnw_pkg::ST_IDLE;
        endcase
    end

    // Scan offsets: z rows ascending, x ascending, inner rows only at the edges
    always_comb begin
        dx_next  = dx_reg;
        dz_next  = dz_reg;
        r_next   = r_reg;
        clr_next = clr_reg;
        case (st_reg)
            gnw_pkg::ST_IDLE: begin
                dx_next  = '0;
                dz_next  = '0;
                r_next   = '0;
                clr_next = '0;
            end
            gnw_pkg::ST_CLEAR: clr_next = clr_reg + AW'(1);
            gnw_pkg::ST_CHECK: begin
                if (dz_reg == rr && dx_reg == rr) begin
                    r_next  = r_reg + 5'd1;
                    dx_next = -(rr + 10'sd1);
                    dz_next = -(rr + 10'sd1);
                end else if (dx_reg == rr) begin
                    dx_next = -rr;
                    dz_next = dz_reg + 10'sd1;
                end else if (row_edge) begin
                    dx_next = dx_reg + 10'sd1;
                end else begin
                    dx_next = rr;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= gnw_pkg::ST_CLEAR;
            ov_reg   <= 1'b0;
            boot_reg <= 1'b1;
        end else begin
            st_reg <= st_next;
            if (fin) ov_reg <= 1'b1;
            else if (m_valid && m_ready) ov_reg <= 1'b0;
            if (st_reg == gnw_pkg::ST_IDLE) boot_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else begin
            clr_reg <= clr_next;
        end
        dx_reg <= dx_next;
        dz_reg <= dz_next;
        r_reg  <= r_next;
        if (take) it_reg <= q_item;
    end

    // Map port: at most one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (st_reg == gnw_pkg::ST_CLEAR) begin
            map_mem[clr_reg] <= 1'b0;
        end else if (st_reg == gnw_pkg::ST_READ && it_reg.op == gnw_pkg::OP_SET && in_grid) begin
            map_mem[addr] <= it_reg.walk_value;
        end
        rd_reg <= map_mem[(it_reg.op == gnw_pkg::OP_INDEX) ? idx_addr : addr];
        chk_inside_reg <= (it_reg.op == gnw_pkg::OP_INDEX) ? idx_ok : in_grid;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (st_reg == gnw_pkg::ST_IDLE && take) begin
            ohit_reg <= 1'b0;
            ox_reg   <= 9'(signed'(q_item.cell_x));
            oz_reg   <= 9'(signed'(q_item.cell_z));
        end else if (st_reg == gnw_pkg::ST_CLEAR) begin
            ohit_reg <= (it_reg.op == gnw_pkg::OP_CLEAR);
        end else if (st_reg == gnw_pkg::ST_CHECK) begin
            case (it_reg.op)
                gnw_pkg::OP_SET:   ohit_reg <= chk_inside_reg;
                gnw_pkg::OP_QUERY,
                gnw_pkg::OP_INDEX: ohit_reg <= chk_inside_reg && rd_reg;
                gnw_pkg::OP_SEARCH: if (chk_inside_reg && rd_reg) begin
                    ohit_reg <= 1'b1;
                    ox_reg   <= tx[8:0];
                    oz_reg   <= tz[8:0];
                end
                default:           ohit_reg <= 1'b0;
            endcase
        end
    end
endmodule

// ===== rtl/grid_nearest_walkable_search.sv =====
// Walkable-map grid with nearest walkable cell search. Items enter a two-entry
// queue and are carried out one at a time by a sequencer around a map memory
// with one write port and one registered read port. Set, query and index query
// go through a read state and a check state; a clear sweeps the map one cell a
// cycle; a search reads and checks each probed cell in turn, ring by ring out
// to radius R. After reset the same clearing sweep runs before the first item
// is taken. Write the size registers only while the block is idle.
module grid_nearest_walkable_search #(
    parameter int MAX_GRID_DIM      = 64,
    parameter int MAX_SEARCH_RADIUS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  gnw_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output gnw_pkg::out_item_t m_item
);
    logic [6:0]        width_reg, height_reg;
    logic              q_valid, q_ready;
    gnw_pkg::in_item_t q_item;

    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 7'd64;
            height_reg <= 7'd64;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == gnw_pkg::REG_WIDTH)  width_reg  <= pwdata[6:0];
            if (paddr[2] == gnw_pkg::REG_HEIGHT) height_reg <= pwdata[6:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == gnw_pkg::REG_WIDTH) prdata = {25'd0, width_reg};
        else                               prdata = {25'd0, height_reg};
    end

    gnw_front #(.MAX_SEARCH_RADIUS(MAX_SEARCH_RADIUS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_item,
        .q_valid, .q_ready, .q_item
    );

    gnw_exec #(.MAX_GRID_DIM(MAX_GRID_DIM)) u_exec (
        .aclk, .aresetn, .grid_width(width_reg), .grid_height(height_reg),
        .q_valid, .q_ready, .q_item, .m_valid, .m_ready, .m_item
    );
endmodule

// ===== rtl/gnw_checker.sv =====
// Port-level checks
module gnw_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input gnw_pkg::out_item_t m_item,
    input logic               pready
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input item dropped while stalled");
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");
    a_rst_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result after reset");
endmodule

bind grid_nearest_walkable_search gnw_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_item, .pready
);

// ===== tb/sv/grid_nearest_walkable_search_tb.sv =====
`timescale 1ns / 1ps

module grid_nearest_walkable_search_tb;

    localparam int GRID_MAX   = 64;
    localparam int RADIUS_MAX = 16;
    localparam int MAP_SIZE   = GRID_MAX * GRID_MAX;
    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    gnw_pkg::in_item_t  s_item = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    gnw_pkg::out_item_t m_item;

    grid_nearest_walkable_search u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    // Shadow state of the grid
    bit        shadow_map [MAP_SIZE];
    int        cfg_width = 64;
    int        cfg_height = 64;

    gnw_pkg::in_item_t  pending_items [$];
    gnw_pkg::out_item_t expected_results [$];

    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_off_cycles = 0;
    int        mismatch_count = 0;
    longint    cycle_count = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Count cycles and stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int clamp_dim(int v);
        if (v < 1) return 1;
        if (v > GRID_MAX) return GRID_MAX;
        return v;
    endfunction

    function automatic bit cell_inside(int x, int z);
        return x >= 0 && z >= 0 && x < clamp_dim(cfg_width) && z < clamp_dim(cfg_height);
    endfunction

    function automatic bit cell_walkable(int x, int z);
        if (!cell_inside(x, z)) return 1'b0;
        return shadow_map[(z * clamp_dim(cfg_width) + x) % MAP_SIZE];
    endfunction

    // Apply one operation to the shadow map and return its result
    function automatic gnw_pkg::out_item_t grid_apply(gnw_pkg::in_item_t it);
        gnw_pkg::out_item_t res;
        int cx, cz, rad, total, dx;
        bit found;
        cx = $signed(it.cell_x);
        cz = $signed(it.cell_z);
        rad = it.search_radius;
        found = 1'b0;
        res.out_x = 9'(cx);
        res.out_z = 9'(cz);
        res.hit = 1'b0;
        case (it.op)
            gnw_pkg::OP_CLEAR: begin
                foreach (shadow_map[i]) shadow_map[i] = 1'b0;
                res.hit = 1'b1;
            end
            gnw_pkg::OP_SET: begin
                if (cell_inside(cx, cz)) begin
                    shadow_map[(cz * clamp_dim(cfg_width) + cx) % MAP_SIZE] = it.walk_value;
                    res.hit = 1'b1;
                end
            end
            gnw_pkg::OP_QUERY: res.hit = cell_walkable(cx, cz);
            gnw_pkg::OP_INDEX: begin
                total = clamp_dim(cfg_width) * clamp_dim(cfg_height);
                if (it.linear_index < total) res.hit = shadow_map[it.linear_index];
            end
            gnw_pkg::OP_SEARCH: begin
                if (rad > RADIUS_MAX) rad = RADIUS_MAX;
                if (cell_walkable(cx, cz)) begin
                    res.hit = 1'b1;
                end else begin
                    for (int r = 1; r <= rad && !found; r++) begin
                        for (int dz = -r; dz <= r && !found; dz++) begin
                            dx = -r;
                            while (dx <= r && !found) begin
                                if (cell_walkable(cx + dx, cz + dz)) begin
                                    found = 1'b1;
                                    res.out_x = 9'(cx + dx);
                                    res.out_z = 9'(cz + dz);
                                end
                                dx += (dz == -r || dz == r) ? 1 : 2 * r;
                            end
                        end
                    end
                    res.hit = found;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Drive items from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // hold the offered item
        end else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            s_item <= pending_items.pop_front();
            s_valid <= 1'b1;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Predict at acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(grid_apply(s_item));
        end
    end

    // Receiver stalls, including a long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin
        gnw_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result: hit=%0b x=%0d z=%0d", m_item.hit,
                             $signed(m_item.out_x), $signed(m_item.out_z));
            end else begin
                want = expected_results.pop_front();
                if (m_item !== want) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display({"result mismatch: expected hit=%0b x=%0d z=%0d,",
                                  " got hit=%0b x=%0d z=%0d"},
                                 want.hit, $signed(want.out_x), $signed(want.out_z),
                                 m_item.hit, $signed(m_item.out_x), $signed(m_item.out_z));
                end
            end
        end
    end

    function automatic gnw_pkg::in_item_t make_item(gnw_pkg::op_t op, int x, int z,
                                                    bit wv = 1'b1, int lin = 0, int rad = 0);
        gnw_pkg::in_item_t it;
        it.op = op;
        it.cell_x = 8'(x);
        it.cell_z = 8'(z);
        it.walk_value = wv;
        it.linear_index = 12'(lin);
        it.search_radius = 5'(rad);
        return it;
    endfunction

    task automatic write_reg(logic [0:0] idx, int value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == gnw_pkg::REG_WIDTH) cfg_width = value & 'h7F;
        else cfg_height = value & 'h7F;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        // let a trailing clear sweep finish
        repeat (MAP_SIZE + 100) @(posedge aclk);
    endtask

    // Random item mix, well formed around the grid, with some noise
    function automatic gnw_pkg::in_item_t random_item();
        int w, h, sel;
        w = clamp_dim(cfg_width);
        h = clamp_dim(cfg_height);
        sel = $urandom_range(99);
        if (sel < 1)
            return make_item(gnw_pkg::OP_CLEAR, $urandom_range(255), $urandom_range(255));
        if (sel < 40)
            return make_item(gnw_pkg::OP_SET, $urandom_range(w + 1) - 1,
                             $urandom_range(h + 1) - 1,
                             $urandom_range(99) < 70, $urandom_range(4095));
        if (sel < 55)
            return make_item(gnw_pkg::OP_QUERY, $urandom_range(w + 1) - 1,
                             $urandom_range(h + 1) - 1, $urandom_range(1));
        if (sel < 65)
            return make_item(gnw_pkg::OP_INDEX, $urandom_range(255), $urandom_range(255),
                             $urandom_range(1),
                             ($urandom_range(3) == 0) ? $urandom_range(4095)
                                                      : $urandom_range(w * h));
        if (sel < 93)
            return make_item(gnw_pkg::OP_SEARCH, $urandom_range(w + 3) - 2,
                             $urandom_range(h + 3) - 2,
                             $urandom_range(1), $urandom_range(4095),
                             ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(5));
        if (sel < 97)
            return make_item(gnw_pkg::op_t'($urandom_range(7)), $urandom_range(255),
                             $urandom_range(255),
                             $urandom_range(1), $urandom_range(4095), $urandom_range(3));
        return make_item(gnw_pkg::op_t'($urandom_range(5, 7)), $urandom_range(255),
                         $urandom_range(255),
                         $urandom_range(1), $urandom_range(4095), $urandom_range(31));
    endfunction

    initial begin
        int sizes [6][2];
        sizes = '{'{64, 64}, '{1, 1}, '{5, 7}, '{64, 3}, '{0, 127}, '{13, 64}};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, each operation and special cases
        pending_items.push_back(make_item(gnw_pkg::OP_QUERY, 0, 0));
        pending_items.push_back(make_item(gnw_pkg::OP_SET, 63, 63, 1'b1));
        pending_items.push_back(make_item(gnw_pkg::OP_SET, 0, 0, 1'b1));
        pending_items.push_back(make_item(gnw_pkg::OP_SET, 64, 0, 1'b1));
        pending_items.push_back(make_item(gnw_pkg::OP_SET, -1, 5, 1'b1));
        pending_items.push_back(make_item(gnw_pkg::OP_SET, -128, 127, 1'b1));
        pending_items.push_back(make_item(gnw_pkg::OP_QUERY, 63, 63));
        pending_items.push_back(make_item(gnw_pkg::OP_QUERY, 127, -128));
        pending_items.push_back(make_item(gnw_pkg::OP_INDEX, 0, 0, 0, 4095));
        pending_items.push_back(make_item(gnw_pkg::OP_INDEX, 0, 0, 0, 0));
        pending_items.push_back(make_item(gnw_pkg::OP_SEARCH, 63, 63, 0, 0, 0));
        pending_items.push_back(make_item(gnw_pkg::OP_SEARCH, 60, 60, 0, 0, 31));
        pending_items.push_back(make_item(gnw_pkg::OP_SEARCH, -5, -5, 0, 0, 16));
        pending_items.push_back(make_item(gnw_pkg::OP_SEARCH, 30, 30, 0, 0, 2));
        pending_items.push_back(make_item(gnw_pkg::OP_SET, 0, 0, 1'b0));
        pending_items.push_back(make_item(gnw_pkg::op_t'(3'd7), -1, -1, 1'b1, 4095, 31));
        pending_items.push_back(make_item(gnw_pkg::op_t'(3'd5), 5, 5, 1'b1, 100, 3));
        pending_items.push_back(make_item(gnw_pkg::OP_CLEAR, 127, -128));
        pending_items.push_back(make_item(gnw_pkg::OP_QUERY, 63, 63));
        drain();

        // Resize without clear, then saturating sizes
        write_reg(gnw_pkg::REG_WIDTH, 17);
        write_reg(gnw_pkg::REG_HEIGHT, 9);
        pending_items.push_back(make_item(gnw_pkg::OP_SET, 16, 8, 1'b1));
        pending_items.push_back(make_item(gnw_pkg::OP_SEARCH, 10, 4, 0, 0, 10));
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            write_reg(gnw_pkg::REG_WIDTH, sizes[ph % 6][0]);
            write_reg(gnw_pkg::REG_HEIGHT, sizes[ph % 6][1]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            if (ph == 4) hold_off_cycles = 3000;
            pending_items.push_back(make_item(gnw_pkg::OP_CLEAR, 0, 0));
            for (int n = 0; n < 125; n++) pending_items.push_back(random_item());
            drain();
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
